>>> design/trs_pkg.sv
// Shared constants, register indexes and types for the triangle row span block.
// No dependencies; every other file of the block imports this package.
package trs_pkg;

    // Vertex coordinate width (signed); supported range 8 to 24.
    localparam int COORD_BITS    = 16;
    localparam int COL_BITS      = 12;
    localparam int XCNT_BITS     = COL_BITS + 1;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (COORD_BITS > COL_BITS) ? COORD_BITS : COL_BITS;

    // Operand width: holds a vertex difference and a column minus a vertex,
    // including the column one past the clip limit.
    localparam int WIDE_BITS = ((COORD_BITS > XCNT_BITS) ? COORD_BITS : XCNT_BITS) + 2;
    localparam int PROD_BITS = 2 * WIDE_BITS;
    localparam int EDGE_BITS = PROD_BITS + 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_A_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_A_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_B_X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_B_Y = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_C_X = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_C_Y = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LEFT  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_RIGHT = 3'd7;

    localparam logic [COL_BITS-1:0] CLIP_RIGHT_RESET = {COL_BITS{1'b1}};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
    } tri_cfg_t;

    // One classified row request waiting for the scan engine.
    typedef struct packed {
        logic [COL_BITS-1:0] row;
        logic [COL_BITS-1:0] xl;
        logic [COL_BITS-1:0] xr;
        logic                empty;
    } row_job_t;

endpackage

>>> design/trs_ifs.sv
// Handshake channel interfaces of the triangle row span block.
// Depends on trs_pkg for field widths.
interface trs_cfg_if;
    import trs_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface trs_row_if;
    import trs_pkg::*;
    logic                valid;
    logic                ready;
    logic [COL_BITS-1:0] row;
    modport source (output valid, output row, input ready);
    modport sink   (input valid, input row, output ready);
endinterface

interface trs_span_if;
    import trs_pkg::*;
    logic                valid;
    logic                ready;
    logic [COL_BITS-1:0] row_echo;
    logic                span_found;
    logic [COL_BITS-1:0] span_start;
    logic [COL_BITS-1:0] span_end;
    modport source (output valid, output row_echo, output span_found,
                    output span_start, output span_end, input ready);
    modport sink   (input valid, input row_echo, input span_found,
                    input span_start, input span_end, output ready);
endinterface

>>> design/trs_front.sv
// Front end: configuration registers, row acceptance and clipped column range.
// Depends on trs_pkg and trs_ifs.
module trs_front (
    input  logic              clk,
    input  logic              rst_n,
    trs_cfg_if.sink           cfg,
    trs_row_if.sink           req,
    output trs_pkg::tri_cfg_t tri_cfg,
    output logic              push_valid,
    input  logic              push_ready,
    output trs_pkg::row_job_t push_data
);
    import trs_pkg::*;

    tri_cfg_t            tri_reg;
    logic [COL_BITS-1:0] clip_left_reg;
    logic [COL_BITS-1:0] clip_right_reg;

    logic signed [COORD_BITS-1:0] min_x;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [WIDE_BITS-1:0]  min_w;
    logic signed [WIDE_BITS-1:0]  max_w;
    logic signed [WIDE_BITS-1:0]  left_w;
    logic signed [WIDE_BITS-1:0]  right_w;
    logic signed [WIDE_BITS-1:0]  xl_w;
    logic signed [WIDE_BITS-1:0]  xr_w;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_reg        <= '0;
            clip_left_reg  <= '0;
            clip_right_reg <= CLIP_RIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_VERTEX_A_X: tri_reg.ax <= cfg.data[COORD_BITS-1:0];
                REG_VERTEX_A_Y: tri_reg.ay <= cfg.data[COORD_BITS-1:0];
                REG_VERTEX_B_X: tri_reg.bx <= cfg.data[COORD_BITS-1:0];
                REG_VERTEX_B_Y: tri_reg.by <= cfg.data[COORD_BITS-1:0];
                REG_VERTEX_C_X: tri_reg.cx <= cfg.data[COORD_BITS-1:0];
                REG_VERTEX_C_Y: tri_reg.cy <= cfg.data[COORD_BITS-1:0];
                REG_CLIP_LEFT:  clip_left_reg  <= cfg.data[COL_BITS-1:0];
                REG_CLIP_RIGHT: clip_right_reg <= cfg.data[COL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Bounding box in x, clipped to the allowed columns.
    always_comb
    begin
        min_x = tri_reg.ax;
        max_x = tri_reg.ax;
        if (tri_reg.bx < min_x) min_x = tri_reg.bx;
        if (tri_reg.cx < min_x) min_x = tri_reg.cx;
        if (tri_reg.bx > max_x) max_x = tri_reg.bx;
        if (tri_reg.cx > max_x) max_x = tri_reg.cx;
        min_w   = WIDE_BITS'(min_x);
        max_w   = WIDE_BITS'(max_x);
        left_w  = WIDE_BITS'({1'b0, clip_left_reg});
        right_w = WIDE_BITS'({1'b0, clip_right_reg});
        xl_w    = (min_w < left_w)  ? left_w  : min_w;
        xr_w    = (max_w > right_w) ? right_w : max_w;
    end

    assign tri_cfg         = tri_reg;
    assign push_valid      = req.valid;
    assign req.ready       = push_ready;
    assign push_data.row   = req.row;
    assign push_data.xl    = xl_w[COL_BITS-1:0];
    assign push_data.xr    = xr_w[COL_BITS-1:0];
    assign push_data.empty = (xl_w > xr_w);

endmodule

>>> design/trs_queue.sv
// Two-entry job queue between the front end and the scan engine.
// Depends on trs_pkg for the job type.
module trs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  trs_pkg::row_job_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output trs_pkg::row_job_t pop_data
);
    import trs_pkg::*;

    row_job_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

>>> design/trs_back.sv
// Scan engine: edge values through one shared multiplier, column walk, result register.
// Depends on trs_pkg and trs_ifs.
module trs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  trs_pkg::tri_cfg_t tri_cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  trs_pkg::row_job_t pop_data,
    trs_span_if.source        span
);
    import trs_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_RUN    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic [2:0] MUL_LAST = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic [COL_BITS-1:0]         row_reg, row_next;
    logic [COL_BITS-1:0]         xl_reg, xl_next;
    logic [COL_BITS-1:0]         xr_reg, xr_next;
    logic [XCNT_BITS-1:0]        x_reg, x_next;
    logic signed [EDGE_BITS-1:0] k_reg, k_next;
    logic signed [EDGE_BITS-1:0] s_reg, s_next;
    logic signed [EDGE_BITS-1:0] t_reg, t_next;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic                        found_reg, found_next;
    logic [COL_BITS-1:0]         start_reg, start_next;
    logic [COL_BITS-1:0]         end_reg, end_next;

    logic                        out_valid_reg, out_valid_next;
    logic [COL_BITS-1:0]         out_row_reg;
    logic                        out_found_reg;
    logic [COL_BITS-1:0]         out_start_reg;
    logic [COL_BITS-1:0]         out_end_reg;
    logic                        out_load;

    logic signed [WIDE_BITS-1:0]   ax_w, ay_w;
    logic signed [WIDE_BITS-1:0]   v1x, v1y, v2x, v2y, qx, qy;
    logic signed [WIDE_BITS-1:0]   mul_a, mul_b;
    logic signed [PROD_BITS-1:0]   prod_full;
    logic signed [EDGE_BITS-1:0]   prod_ext;
    logic signed [EDGE_BITS:0]     st_sum;
    logic signed [EDGE_BITS:0]     k_wide;
    logic                          in_tri;
    logic                          x_in_range;
    logic [XCNT_BITS-1:0]          x_last;

    assign ax_w = WIDE_BITS'(tri_cfg.ax);
    assign ay_w = WIDE_BITS'(tri_cfg.ay);
    assign v1x  = WIDE_BITS'(tri_cfg.bx) - ax_w;
    assign v1y  = WIDE_BITS'(tri_cfg.by) - ay_w;
    assign v2x  = WIDE_BITS'(tri_cfg.cx) - ax_w;
    assign v2y  = WIDE_BITS'(tri_cfg.cy) - ay_w;
    assign qx   = WIDE_BITS'({1'b0, xl_reg}) - ax_w;
    assign qy   = WIDE_BITS'({1'b0, row_reg}) - ay_w;

    // Product order: k = v1x*v2y - v1y*v2x, s = qx*v2y - qy*v2x, t = v1x*qy - v1y*qx.
    always_comb
    begin
        case (cnt_reg)
            3'd0:    begin mul_a = v1x; mul_b = v2y; end
            3'd1:    begin mul_a = v1y; mul_b = v2x; end
            3'd2:    begin mul_a = qx;  mul_b = v2y; end
            3'd3:    begin mul_a = qy;  mul_b = v2x; end
            3'd4:    begin mul_a = v1x; mul_b = qy;  end
            3'd5:    begin mul_a = v1y; mul_b = qx;  end
            default: begin mul_a = '0;  mul_b = '0;  end
        endcase
    end

    assign prod_full = mul_a * mul_b;
    assign prod_ext  = EDGE_BITS'(prod_reg);

    // Inside test; the sign of k picks the orientation.
    assign st_sum = (EDGE_BITS+1)'(s_reg) + (EDGE_BITS+1)'(t_reg);
    assign k_wide = (EDGE_BITS+1)'(k_reg);
    always_comb
    begin
        if (!k_reg[EDGE_BITS-1])
            in_tri = !s_reg[EDGE_BITS-1] && !t_reg[EDGE_BITS-1] && (st_sum <= k_wide);
        else
            in_tri = s_reg[EDGE_BITS-1] && t_reg[EDGE_BITS-1] && (st_sum > k_wide);
    end

    assign x_in_range = (x_reg <= {1'b0, xr_reg});
    assign x_last     = x_reg - XCNT_BITS'(1);
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || span.ready);
    assign pop_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        row_next   = row_reg;
        xl_next    = xl_reg;
        xr_next    = xr_reg;
        x_next     = x_reg;
        k_next     = k_reg;
        s_next     = s_reg;
        t_next     = t_reg;
        found_next = found_reg;
        start_next = start_reg;
        end_next   = end_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    row_next   = pop_data.row;
                    xl_next    = pop_data.xl;
                    xr_next    = pop_data.xr;
                    cnt_next   = 3'd0;
                    found_next = 1'b0;
                    start_next = '0;
                    end_next   = '0;
                    state_next = pop_data.empty ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                // Accumulate the product registered in the previous cycle.
                case (cnt_reg)
                    3'd1:    k_next = prod_ext;
                    3'd2:    k_next = k_reg - prod_ext;
                    3'd3:    s_next = prod_ext;
                    3'd4:    s_next = s_reg - prod_ext;
                    3'd5:    t_next = prod_ext;
                    3'd6:    t_next = t_reg - prod_ext;
                    default: ;
                endcase
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    x_next     = {1'b0, xl_reg};
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (!x_in_range)
                    state_next = ST_DONE;
                else
                begin
                    if (in_tri)
                    begin
                        start_next = x_reg[COL_BITS-1:0];
                        state_next = ST_RUN;
                    end
                    s_next = s_reg + EDGE_BITS'(v2y);
                    t_next = t_reg - EDGE_BITS'(v1y);
                    x_next = x_reg + XCNT_BITS'(1);
                end
            end
            ST_RUN:
            begin
                if (!x_in_range || !in_tri)
                begin
                    found_next = 1'b1;
                    end_next   = x_last[COL_BITS-1:0];
                    state_next = ST_DONE;
                end
                else
                begin
                    s_next = s_reg + EDGE_BITS'(v2y);
                    t_next = t_reg - EDGE_BITS'(v1y);
                    x_next = x_reg + XCNT_BITS'(1);
                end
            end
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (span.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        xl_reg    <= xl_next;
        xr_reg    <= xr_next;
        x_reg     <= x_next;
        k_reg     <= k_next;
        s_reg     <= s_next;
        t_reg     <= t_next;
        prod_reg  <= prod_full;
        found_reg <= found_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        if (out_load)
        begin
            out_row_reg   <= row_reg;
            out_found_reg <= found_reg;
            out_start_reg <= start_reg;
            out_end_reg   <= end_reg;
        end
    end

    assign span.valid      = out_valid_reg;
    assign span.row_echo   = out_row_reg;
    assign span.span_found = out_found_reg;
    assign span.span_start = out_start_reg;
    assign span.span_end   = out_end_reg;

endmodule

>>> design/triangle_row_span.sv
// The scan engine takes one row at a time and walks one column a cycle, from the clipped
//   left end to one past the first covered run, or past the right end if none is
//   covered (up to 4097 columns); an empty clipped range skips the walk.
// The edge values take turns on one shared multiplier before the walk starts.
// Reset (rst_n, async, active low): clears queue, scan state and output valid;
//   vertices reset to 0, clip_left to 0, clip_right to 4095.
//
// Top level of the triangle row span block; depends on trs_pkg, trs_ifs, trs_front,
// trs_queue and trs_back.
module triangle_row_span (
    input  logic clk,
    input  logic rst_n,
    trs_cfg_if.sink    cfg,
    trs_row_if.sink    req,
    trs_span_if.source span
);
    import trs_pkg::*;

    tri_cfg_t tri_cfg;
    row_job_t push_data;
    row_job_t pop_data;
    logic     push_valid;
    logic     push_ready;
    logic     pop_valid;
    logic     pop_ready;

    // Front end: hold the registers, accept a row item and work out the clipped
    // column range and whether it is empty.
    trs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req        (req),
        .tri_cfg    (tri_cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Queue: let the front keep taking items while the scan engine is busy.
    trs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Scan engine: form k, s and t at the left end, walk to the first inside
    // column, then on to the end of that run, and drive the result register.
    trs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tri_cfg   (tri_cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .span      (span)
    );

endmodule

>>> design/trs_checker.sv
// Port-level checks for triangle_row_span, attached by bind.
// Depends on trs_pkg for field widths.
module trs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         span_valid,
    input logic                         span_ready,
    input logic [trs_pkg::COL_BITS-1:0] row_echo,
    input logic                         span_found,
    input logic [trs_pkg::COL_BITS-1:0] span_start,
    input logic [trs_pkg::COL_BITS-1:0] span_end
);
    import trs_pkg::*;

    // Items accepted but not yet delivered.
    logic [2:0] pending_reg;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = req_valid && req_ready;
    assign out_fire = span_valid && span_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 3'd0;
        else if (in_fire && !out_fire)
            pending_reg <= pending_reg + 3'd1;
        else if (out_fire && !in_fire)
            pending_reg <= pending_reg - 3'd1;
    end

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid |-> pending_reg != 3'd0)
        else $error("result shown with no item outstanding");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && !span_ready |=> span_valid && $stable(row_echo)
            && $stable(span_found) && $stable(span_start) && $stable(span_end))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && !span_found |-> span_start == '0 && span_end == '0)
        else $error("span bounds not zero without a span");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid && span_found |-> span_start <= span_end)
        else $error("span start beyond span end");

endmodule

bind triangle_row_span trs_checker u_trs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .span_valid (span.valid),
    .span_ready (span.ready),
    .row_echo   (span.row_echo),
    .span_found (span.span_found),
    .span_start (span.span_start),
    .span_end   (span.span_end)
);

>>> bench/triangle_row_span_tb.sv
// Self-checking bench for triangle_row_span: sets up triangles and clip ranges, asks
// for rows and checks every returned span against a column-walking predictor.
// Depends on trs_pkg, the trs_*_if channel interfaces and the triangle_row_span RTL.
module triangle_row_span_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import trs_pkg::*;

    // Quiet time with no handshake on any channel before the run is called hung.
    // It must outlast the slowest legal item, which walks 4097 columns, and the long receiver hold.
    localparam int STALL_LIMIT  = 50000;
    localparam int RANDOM_ROWS  = 340;
    localparam int REPORT_LIMIT = 100;
    localparam int LONG_HOLD    = 1500;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    // One expected result item, laid out like the span channel.
    typedef struct packed {
        logic [COL_BITS-1:0] row_echo;
        logic                span_found;
        logic [COL_BITS-1:0] span_start;
        logic [COL_BITS-1:0] span_end;
    } span_t;

    logic clk = 1'b0;
    logic rst_n;

    trs_cfg_if  cfg_ch ();
    trs_row_if  row_ch ();
    trs_span_if span_ch ();

    triangle_row_span dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (row_ch),
        .span  (span_ch)
    );

    // Shadow of the block's registers, updated on each accepted register write.
    tri_cfg_t            tri_shadow = '0;
    logic [COL_BITS-1:0] clip_lo    = '0;
    logic [COL_BITS-1:0] clip_hi    = CLIP_RIGHT_RESET;

    logic [COL_BITS-1:0] row_q[$];          // rows waiting to be offered
    span_t               expected_spans[$]; // spans owed by the block, oldest first

    bit  row_fire     = 1'b0;
    bit  rx_hold      = 1'b0;
    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    int  quiet_cycles = 0;
    int  mismatches   = 0;
    int  reports      = 0;
    int  rows_sent    = 0;
    int  spans_seen   = 0;
    int  spans_hit    = 0;
    int  reg_writes   = 0;
    int  setups       = 0;
    int  random_rows  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint lo3(input longint a, input longint b, input longint c);
        longint m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic longint hi3(input longint a, input longint b, input longint c);
        longint m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Inside test on the edge values; the sign of the winding decides which side counts,
    // and with clockwise winding the edges themselves are excluded.
    function automatic bit edge_inside(input longint s, input longint t, input longint k);
        if (k >= 0)
            return s >= 0 && t >= 0 && s + t <= k;
        return s < 0 && t < 0 && s + t > k;
    endfunction

    // Walk the clipped bounding box of the current triangle along one row: skip to the
    // first covered column, then run to the end of that covered stretch.
    function automatic span_t span_predict(input logic [COL_BITS-1:0] row);
        longint ax, ay, bx, by, cx, cy;
        longint v1x, v1y, v2x, v2y, k, s, t, xl, xr, x, y, lim_l, lim_r;
        span_t  p;
        ax = longint'($signed(tri_shadow.ax));
        ay = longint'($signed(tri_shadow.ay));
        bx = longint'($signed(tri_shadow.bx));
        by = longint'($signed(tri_shadow.by));
        cx = longint'($signed(tri_shadow.cx));
        cy = longint'($signed(tri_shadow.cy));
        // zero-extend the unsigned fields before any signed compare
        y     = longint'(row);
        lim_l = longint'(clip_lo);
        lim_r = longint'(clip_hi);
        v1x = bx - ax;
        v1y = by - ay;
        v2x = cx - ax;
        v2y = cy - ay;
        k   = v1x * v2y - v1y * v2x;
        xl  = lo3(ax, bx, cx);
        xr  = hi3(ax, bx, cx);
        if (xl < lim_l)
            xl = lim_l;
        if (xr > lim_r)
            xr = lim_r;
        p.row_echo   = row;
        p.span_found = 1'b0;
        p.span_start = '0;
        p.span_end   = '0;
        if (xl <= xr)
        begin
            s = (xl - ax) * v2y - (y - ay) * v2x;
            t = v1x * (y - ay) - v1y * (xl - ax);
            x = xl;
            while (x <= xr && !edge_inside(s, t, k))
            begin
                s += v2y;
                t -= v1y;
                x++;
            end
            if (x <= xr)
            begin
                p.span_found = 1'b1;
                p.span_start = COL_BITS'(x);
                while (x <= xr && edge_inside(s, t, k))
                begin
                    s += v2y;
                    t -= v1y;
                    x++;
                end
                p.span_end = COL_BITS'(x - 1);
            end
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Row driver: offer at the falling edge, hold until taken
    // ------------------------------------------------------------------

    // Keep an offered item steady until the rising edge that takes it; only then
    // consider the next row, or go idle at the sender's current idle rate.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            row_ch.valid <= 1'b0;
            row_ch.row   <= '0;
        end
        else if (!row_ch.valid || row_fire)
        begin
            if (row_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                row_ch.valid <= 1'b1;
                row_ch.row   <= row_q[0];
            end
            else
                row_ch.valid <= 1'b0;
        end
    end

    // On each accepted row, drop it from the pending queue and predict its span with
    // the registers as they stand now (they only change while the block is idle).
    always @(posedge clk)
    begin
        row_fire <= row_ch.valid && row_ch.ready;
        if (row_ch.valid && row_ch.ready)
        begin
            expected_spans.push_back(span_predict(row_ch.row));
            void'(row_q.pop_front());
            rows_sent++;
        end
    end

    // Receiver: stall at random, or hold off completely while rx_hold is set.
    always @(negedge clk)
        span_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);

    // ------------------------------------------------------------------
    // Span monitor and checker
    // ------------------------------------------------------------------

    task automatic flag_field(input string field, input logic [COL_BITS-1:0] want,
                              input logic [COL_BITS-1:0] got);
        mismatches++;
        if (reports < REPORT_LIMIT)
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
        reports++;
    endtask

    always @(posedge clk)
    begin : span_check
        span_t want;
        if (span_ch.valid && span_ch.ready)
        begin
            spans_seen++;
            if (expected_spans.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: span with nothing expected, expected none, got row %h",
                         $time, span_ch.row_echo);
            end
            else
            begin
                want = expected_spans.pop_front();
                if (want.span_found)
                    spans_hit++;
                if (span_ch.row_echo !== want.row_echo)
                    flag_field("row_echo", want.row_echo, span_ch.row_echo);
                if (span_ch.span_found !== want.span_found)
                    flag_field("span_found", COL_BITS'(want.span_found),
                               COL_BITS'(span_ch.span_found));
                if (span_ch.span_start !== want.span_start)
                    flag_field("span_start", want.span_start, span_ch.span_start);
                if (span_ch.span_end !== want.span_end)
                    flag_field("span_end", want.span_end, span_ch.span_end);
            end
        end
    end

    // Watchdog: count cycles with no handshake anywhere; a hung block ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (row_ch.valid && row_ch.ready) || (span_ch.valid && span_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles, %0d spans still owed",
                     $time, quiet_cycles, expected_spans.size());
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            IDLE_SENDER:   begin tx_idle_pct = 49; rx_stall_pct = 0;  end
            IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
            default:       begin tx_idle_pct = 14; rx_stall_pct = 14; end
        endcase
    endtask

    // Drive one register write; call at a falling edge, returns at a falling edge with
    // valid still high so back-to-back writes never drop and re-raise it in one step.
    task automatic reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_VERTEX_A_X: tri_shadow.ax = d[COORD_BITS-1:0];
            REG_VERTEX_A_Y: tri_shadow.ay = d[COORD_BITS-1:0];
            REG_VERTEX_B_X: tri_shadow.bx = d[COORD_BITS-1:0];
            REG_VERTEX_B_Y: tri_shadow.by = d[COORD_BITS-1:0];
            REG_VERTEX_C_X: tri_shadow.cx = d[COORD_BITS-1:0];
            REG_VERTEX_C_Y: tri_shadow.cy = d[COORD_BITS-1:0];
            REG_CLIP_LEFT:  clip_lo = d[COL_BITS-1:0];
            REG_CLIP_RIGHT: clip_hi = d[COL_BITS-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
    endtask

    // Load a whole setup. Only call while idle. Clip writes carry random upper data bits,
    // which the block must ignore.
    task automatic set_config(input int ax, input int ay, input int bx, input int by,
                              input int cx, input int cy, input int cl, input int cr);
        logic [CFG_DATA_BITS-1:0] d;
        @(negedge clk);
        reg_write(REG_VERTEX_A_X, CFG_DATA_BITS'(ax));
        reg_write(REG_VERTEX_A_Y, CFG_DATA_BITS'(ay));
        reg_write(REG_VERTEX_B_X, CFG_DATA_BITS'(bx));
        reg_write(REG_VERTEX_B_Y, CFG_DATA_BITS'(by));
        reg_write(REG_VERTEX_C_X, CFG_DATA_BITS'(cx));
        reg_write(REG_VERTEX_C_Y, CFG_DATA_BITS'(cy));
        d = CFG_DATA_BITS'($urandom);
        d[COL_BITS-1:0] = COL_BITS'(cl);
        reg_write(REG_CLIP_LEFT, d);
        d = CFG_DATA_BITS'($urandom);
        d[COL_BITS-1:0] = COL_BITS'(cr);
        reg_write(REG_CLIP_RIGHT, d);
        cfg_ch.valid <= 1'b0;
        setups++;
    endtask

    // Pause the sender until every queued row is taken and every span has come back.
    task automatic wait_drain();
        do
            @(negedge clk);
        while (row_q.size() != 0 || expected_spans.size() != 0);
    endtask

    function automatic int jitter(input int sz);
        return int'($urandom_range(2 * sz)) - sz;
    endfunction

    function automatic logic [COL_BITS-1:0] clamp_col(input longint v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return '1;
        return COL_BITS'(v);
    endfunction

    // One random setup followed by a burst of rows. Most triangles are small so the
    // column walk stays short; a few span the full coordinate range and the full width.
    task automatic run_random_phase(input int phase);
        int kind, sz, xm, ym, ax, ay, bx, by, cx, cy, cl, cr, n, pick;
        longint xmin, xmax, ymin, ymax;
        logic [COL_BITS-1:0] r;
        set_idling(idle_mode_e'(phase % 4));
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            // small triangle anywhere on the screen
            sz = $urandom_range(1, 48);
            xm = $urandom_range(0, 4095);
            ym = $urandom_range(0, 4095);
            ax = xm + jitter(sz); ay = ym + jitter(sz);
            bx = xm + jitter(sz); by = ym + jitter(sz);
            cx = xm + jitter(sz); cy = ym + jitter(sz);
        end
        else if (kind < 85)
        begin
            // straddle the origin so vertices go negative and clip_left bites
            sz = $urandom_range(20, 300);
            xm = int'($urandom_range(0, 400)) - 150;
            ym = int'($urandom_range(0, 400)) - 150;
            ax = xm + jitter(sz); ay = ym + jitter(sz);
            bx = xm + jitter(sz); by = ym + jitter(sz);
            cx = xm + jitter(sz); cy = ym + jitter(sz);
        end
        else if (kind < 95)
        begin
            // degenerate: collinear vertices or two vertices on top of each other
            ax = $urandom_range(0, 4095);
            ay = $urandom_range(0, 4095);
            bx = ax + jitter(40);
            by = ay + jitter(40);
            if ($urandom_range(1))
            begin
                cx = ax + 2 * (bx - ax);
                cy = ay + 2 * (by - ay);
            end
            else
            begin
                cx = bx;
                cy = by;
            end
        end
        else
        begin
            // wild: any coordinate the registers can hold
            ax = int'($urandom_range(65535)) - 32768;
            ay = int'($urandom_range(65535)) - 32768;
            bx = int'($urandom_range(65535)) - 32768;
            by = int'($urandom_range(65535)) - 32768;
            cx = int'($urandom_range(65535)) - 32768;
            cy = int'($urandom_range(65535)) - 32768;
        end
        xmin = lo3(longint'(ax), longint'(bx), longint'(cx));
        xmax = hi3(longint'(ax), longint'(bx), longint'(cx));
        ymin = lo3(longint'(ay), longint'(by), longint'(cy));
        ymax = hi3(longint'(ay), longint'(by), longint'(cy));

        pick = $urandom_range(9);
        if (pick < 4)
        begin
            cl = 0;
            cr = 4095;
        end
        else if (pick < 8)
        begin
            // clip near the triangle's own extent, cutting it on either side
            cl = int'(clamp_col(xmin + jitter(20)));
            cr = int'(clamp_col(xmax + jitter(20)));
        end
        else if (pick == 8)
        begin
            cl = $urandom_range(0, 4095);
            cr = $urandom_range(0, 4095);
        end
        else
        begin
            // crossed clip: no column can be in range
            cl = $urandom_range(2000, 4095);
            cr = $urandom_range(0, cl - 1);
        end
        set_config(ax, ay, bx, by, cx, cy, cl, cr);

        n = (kind >= 95) ? 4 : $urandom_range(8, 30);
        repeat (n)
        begin
            // mostly rows across the triangle and just past it, some anywhere
            if ($urandom_range(99) < 85)
                r = clamp_col(ymin - 2 + longint'($urandom_range(0, 32'(ymax - ymin + 4))));
            else
                r = COL_BITS'($urandom_range(0, 4095));
            row_q.push_back(r);
            random_rows++;
        end
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_seq
        int phase;
        // hold reset and park the register channel before the first edge
        rst_n         = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_idling(IDLE_NONE);

        // Reset registers: every vertex at the origin, so the degenerate point covers
        // column 0 of any row.
        row_q = {row_q, COL_BITS'(0), COL_BITS'(4095)};
        wait_drain();

        // Counter-clockwise right triangle: rows above, on the top edge, through the
        // middle, at the apex, below, and the last row.
        set_config(10, 10, 50, 10, 10, 50, 0, 4095);
        row_q = {row_q, COL_BITS'(9), COL_BITS'(10), COL_BITS'(30), COL_BITS'(50),
                 COL_BITS'(51), COL_BITS'(4095)};
        wait_drain();

        // Same shape wound clockwise: edges no longer count as inside.
        set_config(10, 10, 10, 50, 50, 10, 0, 4095);
        row_q = {row_q, COL_BITS'(10), COL_BITS'(30), COL_BITS'(49)};
        wait_drain();

        // Collinear vertices: only points on the line are covered.
        set_config(0, 0, 20, 20, 40, 40, 0, 4095);
        row_q = {row_q, COL_BITS'(5), COL_BITS'(40)};
        wait_drain();

        // Extreme coordinates, full clip: a full-width walk that finds nothing ...
        set_config(-32768, -32768, 32767, -32768, -32768, 32767, 0, 4095);
        row_q = {row_q, COL_BITS'(0), COL_BITS'(4095)};
        wait_drain();

        // ... and one whose span runs the full width.
        set_config(32767, 32767, -32768, 32767, 32767, -32768, 0, 4095);
        row_q = {row_q, COL_BITS'(0), COL_BITS'(4095)};
        wait_drain();

        // Narrow clip cutting both ends of the span, then a crossed clip.
        set_config(10, 10, 50, 10, 10, 50, 20, 30);
        row_q = {row_q, COL_BITS'(12), COL_BITS'(35)};
        wait_drain();
        set_config(10, 10, 50, 10, 10, 50, 100, 50);
        row_q = {row_q, COL_BITS'(20), COL_BITS'(2048)};
        wait_drain();

        // Back pressure: hold the receiver off for a long stretch while the sender
        // keeps offering, so the block's queue fills and it stalls its input.
        set_config(100, 100, 130, 100, 100, 130, 0, 4095);
        fork
            begin
                @(posedge clk);
                rx_hold = 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                rx_hold = 1'b0;
            end
        join_none
        repeat (40)
            row_q.push_back(COL_BITS'($urandom_range(95, 135)));
        wait_drain();

        // Random setups, cycling through the idling modes.
        phase = 0;
        while (random_rows < RANDOM_ROWS)
        begin
            run_random_phase(phase);
            phase++;
        end

        // Let any stray result surface before the verdict.
        set_idling(IDLE_NONE);
        repeat (64) @(posedge clk);
        if (expected_spans.size() != 0)
        begin
            mismatches += expected_spans.size();
            $display("%0t ns: %0d spans never arrived", $time, expected_spans.size());
        end

        $display("Checked %0d spans (%0d covered) for %0d rows over %0d setups, %0d writes",
                 spans_seen, spans_hit, rows_sent, setups, reg_writes);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
